// File: hdl/ecr_pkg.sv
// ----------------------------------------------------------------------------
// ecr_pkg: shared constants, codes and helpers
// Widths of the collision pipeline, register codes and rounding helpers.
// ----------------------------------------------------------------------------
package ecr_pkg;

    localparam int FRAC_BITS = 16;              // Q.FRAC_BITS of positions/velocities
    localparam int COEF_FRAC = 16;              // speed_coef is Q1.16
    localparam int VW        = 32;              // field width
    localparam int DW        = VW + 1;          // exact difference
    localparam int AW        = VW - 1;          // normalized magnitude
    localparam int SQW       = 2 * AW;          // one square
    localparam int SUMW      = SQW + 1;         // sum of squares
    localparam int RESW      = SUMW + 1;        // root working register
    localparam int SQ_STEPS  = (SUMW + 1) / 2;  // one root bit per stage
    localparam int RTW       = VW;              // root width
    localparam int QW        = FRAC_BITS + 1;   // |n| <= 1.0
    localparam int NW        = QW + 1;          // signed normal component
    localparam int REMW      = RTW + FRAC_BITS; // divider remainder
    localparam int PRW       = NW + DW;         // n * k
    localparam int DOTW      = PRW + 1;
    localparam int PW        = DOTW + 1 - FRAC_BITS;
    localparam int IXPW      = PW + NW;
    localparam int IXW       = IXPW - FRAC_BITS;
    localparam int NVW       = IXW + 1;
    localparam int COEF_W    = 17;
    localparam int MINSPD_W  = 31;
    localparam int SCW       = NVW + COEF_W + 1;
    localparam int CFG_DW    = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [COEF_W-1:0]   COEF_RESET   = COEF_W'(65536);
    localparam logic [MINSPD_W-1:0] MINSPD_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_COEF = 2'd0,
        CFG_MIN_SPEED  = 2'd1
    } t_cfg_idx;

    // arithmetic shift right that rounds toward zero
    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] m;
        m = -v;
        if (v < 0) begin
            return -(m >>> s);
        end
        return v >>> s;
    endfunction

    function automatic logic signed [VW-1:0] sat_v(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[VW-1:0];
    endfunction

endpackage

// File: hdl/elastic_collision_response.sv
// ----------------------------------------------------------------------------
// elastic_collision_response: two-body elastic bounce in Q16.16
// Unit normal, impulse, velocity update, optional post-bounce scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat carries both bodies' position and velocity.
//   A beat is taken at a clock edge with i_valid high and o_stall low.
//   Output channel: one beat per input beat, in order, with the four
//   resolved velocities and the degenerate flag; taken when o_valid is
//   high and i_stall is low.
//   Config: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (0 speed_coef, 1 min_speed); other indexes are dropped. Write only
//   while the pipeline is empty.
//   Pipeline: 4 setup stages, 32 root stages, 18 stages of two parallel
//   restoring dividers and 7 multiply/finish stages at FRAC_BITS = 16.
//   Throughput: one beat per cycle while not stalled; every stage is a register slice.
//   Stall: while the output register holds an untaken beat and i_stall is
//   high, the whole pipeline freezes and o_stall goes high; nothing is lost
//   or repeated. An empty output register lets the pipeline advance.
//   Reset: synchronous, active low; clears all valid bits and loads the
//   register defaults (speed_coef = 1.0, min_speed = 0).
// ----------------------------------------------------------------------------
module elastic_collision_response (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ecr_pkg::VW-1:0]       i_first_x,
    input  logic signed [ecr_pkg::VW-1:0]       i_first_y,
    input  logic signed [ecr_pkg::VW-1:0]       i_first_vx,
    input  logic signed [ecr_pkg::VW-1:0]       i_first_vy,
    input  logic signed [ecr_pkg::VW-1:0]       i_second_x,
    input  logic signed [ecr_pkg::VW-1:0]       i_second_y,
    input  logic signed [ecr_pkg::VW-1:0]       i_second_vx,
    input  logic signed [ecr_pkg::VW-1:0]       i_second_vy,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ecr_pkg::VW-1:0]       o_new_first_vx,
    output logic signed [ecr_pkg::VW-1:0]       o_new_first_vy,
    output logic signed [ecr_pkg::VW-1:0]       o_new_second_vx,
    output logic signed [ecr_pkg::VW-1:0]       o_new_second_vy,
    output logic                                o_degenerate,
    input  logic                                i_cfg_we,
    input  logic [ecr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ecr_pkg::CFG_DW-1:0]          i_cfg_wdata
);

    localparam int VW   = ecr_pkg::VW;
    localparam int DW   = ecr_pkg::DW;
    localparam int AW   = ecr_pkg::AW;
    localparam int F    = ecr_pkg::FRAC_BITS;
    localparam int NSQ  = ecr_pkg::SQ_STEPS;
    localparam int NQ   = ecr_pkg::QW;

    // sideband that rides along the long root/divide sections
    typedef struct packed {
        logic                   degen;
        logic                   sx;
        logic                   sy;
        logic [AW-1:0]          ax;
        logic [AW-1:0]          ay;
        logic signed [DW-1:0]   kx;
        logic signed [DW-1:0]   ky;
        logic signed [VW-1:0]   v1x;
        logic signed [VW-1:0]   v1y;
        logic signed [VW-1:0]   v2x;
        logic signed [VW-1:0]   v2y;
    } t_pay;

    logic en;

    // config registers
    logic [ecr_pkg::COEF_W-1:0]   r_coef;
    logic [ecr_pkg::MINSPD_W-1:0] r_minspd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= ecr_pkg::COEF_RESET;
            r_minspd <= ecr_pkg::MINSPD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ecr_pkg::CFG_SPEED_COEF) begin
                r_coef <= i_cfg_wdata[ecr_pkg::COEF_W-1:0];
            end else if (i_cfg_idx == ecr_pkg::CFG_MIN_SPEED) begin
                r_minspd <= i_cfg_wdata[ecr_pkg::MINSPD_W-1:0];
            end
        end
    end

    // global advance: freeze only when the output beat is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---- stage A: differences ----
    logic                 r_a_vld;
    logic signed [DW-1:0] r_a_dx, r_a_dy;
    t_pay                 r_a_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx      <= {i_second_x[VW-1], i_second_x} - {i_first_x[VW-1], i_first_x};
            r_a_dy      <= {i_second_y[VW-1], i_second_y} - {i_first_y[VW-1], i_first_y};
            r_a_pay.kx  <= {i_first_vx[VW-1], i_first_vx} - {i_second_vx[VW-1], i_second_vx};
            r_a_pay.ky  <= {i_first_vy[VW-1], i_first_vy} - {i_second_vy[VW-1], i_second_vy};
            r_a_pay.v1x <= i_first_vx;
            r_a_pay.v1y <= i_first_vy;
            r_a_pay.v2x <= i_second_vx;
            r_a_pay.v2y <= i_second_vy;
            r_a_pay.degen <= 1'b0;
            r_a_pay.sx    <= 1'b0;
            r_a_pay.sy    <= 1'b0;
            r_a_pay.ax    <= '0;
            r_a_pay.ay    <= '0;
        end
    end

    // ---- stage B: magnitudes, normalize below 2^31 ----
    logic [DW-1:0] w_adx, w_ady, w_m, w_sx_mag, w_sy_mag;
    logic          r_b_vld;
    t_pay          r_b_pay;

    assign w_adx = r_a_dx[DW-1] ? DW'(-r_a_dx) : DW'(r_a_dx);
    assign w_ady = r_a_dy[DW-1] ? DW'(-r_a_dy) : DW'(r_a_dy);
    assign w_m   = (w_adx > w_ady) ? w_adx : w_ady;
    assign w_sx_mag = w_m[DW-1] ? (w_adx >> 2) : (w_m[DW-2] ? (w_adx >> 1) : w_adx);
    assign w_sy_mag = w_m[DW-1] ? (w_ady >> 2) : (w_m[DW-2] ? (w_ady >> 1) : w_ady);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_pay.kx    <= r_a_pay.kx;
            r_b_pay.ky    <= r_a_pay.ky;
            r_b_pay.v1x   <= r_a_pay.v1x;
            r_b_pay.v1y   <= r_a_pay.v1y;
            r_b_pay.v2x   <= r_a_pay.v2x;
            r_b_pay.v2y   <= r_a_pay.v2y;
            r_b_pay.degen <= (r_a_dx == '0) && (r_a_dy == '0);
            r_b_pay.sx    <= r_a_dx[DW-1];
            r_b_pay.sy    <= r_a_dy[DW-1];
            r_b_pay.ax    <= w_sx_mag[AW-1:0];
            r_b_pay.ay    <= w_sy_mag[AW-1:0];
        end
    end

    // ---- stage C: squares ----
    logic                       r_c_vld;
    logic [ecr_pkg::SQW-1:0]    r_c_sqx, r_c_sqy;
    t_pay                       r_c_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_sqx <= r_b_pay.ax * r_b_pay.ax;
            r_c_sqy <= r_b_pay.ay * r_b_pay.ay;
            r_c_pay <= r_b_pay;
        end
    end

    // ---- square root: stage 0 holds the sum, one result bit per stage ----
    logic                          r_q_vld [0:NSQ];
    logic [ecr_pkg::SUMW-1:0]      r_q_rem [0:NSQ];
    logic [ecr_pkg::RESW-1:0]      r_q_res [0:NSQ];
    t_pay                          r_q_pay [0:NSQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld[0] <= 1'b0;
        end else if (en) begin
            r_q_vld[0] <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_rem[0] <= ecr_pkg::SUMW'(r_c_sqx) + ecr_pkg::SUMW'(r_c_sqy);
            r_q_res[0] <= '0;
            r_q_pay[0] <= r_c_pay;
        end
    end

    for (genvar gi = 0; gi < NSQ; gi++) begin : g_sqrt
        localparam int SH = 2 * (NSQ - 1 - gi);
        logic [ecr_pkg::RESW-1:0] w_bit, w_trial;

        assign w_bit   = ecr_pkg::RESW'(1) << SH;
        assign w_trial = r_q_res[gi] + w_bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[gi+1] <= 1'b0;
            end else if (en) begin
                r_q_vld[gi+1] <= r_q_vld[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q_pay[gi+1] <= r_q_pay[gi];
                if ({1'b0, r_q_rem[gi]} >= w_trial) begin
                    r_q_rem[gi+1] <= r_q_rem[gi] - w_trial[ecr_pkg::SUMW-1:0];
                    r_q_res[gi+1] <= (r_q_res[gi] >> 1) + w_bit;
                end else begin
                    r_q_rem[gi+1] <= r_q_rem[gi];
                    r_q_res[gi+1] <= r_q_res[gi] >> 1;
                end
            end
        end
    end

    // ---- divide: two restoring dividers, one quotient bit per stage ----
    logic                          r_d_vld [0:NQ];
    logic [ecr_pkg::RTW-1:0]       r_d_div [0:NQ];
    logic [ecr_pkg::REMW-1:0]      r_d_rx  [0:NQ];
    logic [ecr_pkg::REMW-1:0]      r_d_ry  [0:NQ];
    logic [NQ-1:0]                 r_d_qx  [0:NQ];
    logic [NQ-1:0]                 r_d_qy  [0:NQ];
    t_pay                          r_d_pay [0:NQ];
    logic [ecr_pkg::RTW-1:0]       w_root;

    assign w_root = r_q_res[NSQ][ecr_pkg::RTW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else if (en) begin
            r_d_vld[0] <= r_q_vld[NSQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_div[0] <= (w_root == '0) ? ecr_pkg::RTW'(1) : w_root;
            r_d_rx[0]  <= ecr_pkg::REMW'(r_q_pay[NSQ].ax) << F;
            r_d_ry[0]  <= ecr_pkg::REMW'(r_q_pay[NSQ].ay) << F;
            r_d_qx[0]  <= '0;
            r_d_qy[0]  <= '0;
            r_d_pay[0] <= r_q_pay[NSQ];
        end
    end

    for (genvar gj = 0; gj < NQ; gj++) begin : g_div
        localparam int SH = NQ - 1 - gj;
        logic [ecr_pkg::REMW-1:0] w_dsh;

        assign w_dsh = ecr_pkg::REMW'(r_d_div[gj]) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[gj+1] <= 1'b0;
            end else if (en) begin
                r_d_vld[gj+1] <= r_d_vld[gj];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_div[gj+1] <= r_d_div[gj];
                r_d_pay[gj+1] <= r_d_pay[gj];
                if (r_d_rx[gj] >= w_dsh) begin
                    r_d_rx[gj+1] <= r_d_rx[gj] - w_dsh;
                    r_d_qx[gj+1] <= r_d_qx[gj] | (NQ'(1) << SH);
                end else begin
                    r_d_rx[gj+1] <= r_d_rx[gj];
                    r_d_qx[gj+1] <= r_d_qx[gj];
                end
                if (r_d_ry[gj] >= w_dsh) begin
                    r_d_ry[gj+1] <= r_d_ry[gj] - w_dsh;
                    r_d_qy[gj+1] <= r_d_qy[gj] | (NQ'(1) << SH);
                end else begin
                    r_d_ry[gj+1] <= r_d_ry[gj];
                    r_d_qy[gj+1] <= r_d_qy[gj];
                end
            end
        end
    end

    // ---- M1: signed normal, n * k ----
    logic signed [ecr_pkg::NW-1:0]  w_nx, w_ny;
    logic                           r_m1_vld;
    logic signed [ecr_pkg::NW-1:0]  r_m1_nx, r_m1_ny;
    logic signed [ecr_pkg::PRW-1:0] r_m1_px, r_m1_py;
    t_pay                           r_m1_pay;

    assign w_nx = r_d_pay[NQ].sx ? -$signed({1'b0, r_d_qx[NQ]}) : $signed({1'b0, r_d_qx[NQ]});
    assign w_ny = r_d_pay[NQ].sy ? -$signed({1'b0, r_d_qy[NQ]}) : $signed({1'b0, r_d_qy[NQ]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (en) begin
            r_m1_vld <= r_d_vld[NQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_nx  <= w_nx;
            r_m1_ny  <= w_ny;
            r_m1_px  <= w_nx * r_d_pay[NQ].kx;
            r_m1_py  <= w_ny * r_d_pay[NQ].ky;
            r_m1_pay <= r_d_pay[NQ];
        end
    end

    // ---- M2: impulse p = 2 * dot, scaled back ----
    logic signed [63:0]            w_dot2, w_p;
    logic                          r_m2_vld;
    logic signed [ecr_pkg::NW-1:0] r_m2_nx, r_m2_ny;
    logic signed [ecr_pkg::PW-1:0] r_m2_p;
    t_pay                          r_m2_pay;

    assign w_dot2 = (64'(r_m1_px) + 64'(r_m1_py)) <<< 1;
    assign w_p    = ecr_pkg::trunc_shr(w_dot2, F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (en) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_nx  <= r_m1_nx;
            r_m2_ny  <= r_m1_ny;
            r_m2_p   <= w_p[ecr_pkg::PW-1:0];
            r_m2_pay <= r_m1_pay;
        end
    end

    // ---- M3: p * n ----
    logic                            r_m3_vld;
    logic signed [ecr_pkg::IXPW-1:0] r_m3_ipx, r_m3_ipy;
    t_pay                            r_m3_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else if (en) begin
            r_m3_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_ipx <= r_m2_p * r_m2_nx;
            r_m3_ipy <= r_m2_p * r_m2_ny;
            r_m3_pay <= r_m2_pay;
        end
    end

    // ---- M4: impulse components ----
    logic signed [63:0]             w_ix, w_iy;
    logic                           r_m4_vld;
    logic signed [ecr_pkg::IXW-1:0] r_m4_ix, r_m4_iy;
    t_pay                           r_m4_pay;

    assign w_ix = ecr_pkg::trunc_shr(64'(r_m3_ipx), F);
    assign w_iy = ecr_pkg::trunc_shr(64'(r_m3_ipy), F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4_vld <= 1'b0;
        end else if (en) begin
            r_m4_vld <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m4_ix  <= w_ix[ecr_pkg::IXW-1:0];
            r_m4_iy  <= w_iy[ecr_pkg::IXW-1:0];
            r_m4_pay <= r_m3_pay;
        end
    end

    // ---- M5: new velocities; coincident bodies pass through ----
    logic signed [63:0]             w_n1x, w_n1y, w_n2x, w_n2y;
    logic                           r_m5_vld, r_m5_degen;
    logic signed [ecr_pkg::NVW-1:0] r_m5_v1x, r_m5_v1y, r_m5_v2x, r_m5_v2y;

    assign w_n1x = 64'(r_m4_pay.v1x) - (r_m4_pay.degen ? 64'sd0 : 64'(r_m4_ix));
    assign w_n1y = 64'(r_m4_pay.v1y) - (r_m4_pay.degen ? 64'sd0 : 64'(r_m4_iy));
    assign w_n2x = 64'(r_m4_pay.v2x) + (r_m4_pay.degen ? 64'sd0 : 64'(r_m4_ix));
    assign w_n2y = 64'(r_m4_pay.v2y) + (r_m4_pay.degen ? 64'sd0 : 64'(r_m4_iy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m5_vld <= 1'b0;
        end else if (en) begin
            r_m5_vld <= r_m4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m5_v1x   <= w_n1x[ecr_pkg::NVW-1:0];
            r_m5_v1y   <= w_n1y[ecr_pkg::NVW-1:0];
            r_m5_v2x   <= w_n2x[ecr_pkg::NVW-1:0];
            r_m5_v2y   <= w_n2y[ecr_pkg::NVW-1:0];
            r_m5_degen <= r_m4_pay.degen;
        end
    end

    // ---- M6: scale products and per-body scale decision ----
    logic [ecr_pkg::NVW-1:0]          w_mag1, w_mag2;
    logic signed [ecr_pkg::COEF_W:0]  w_coef;
    logic                             r_m6_vld, r_m6_degen, r_m6_sc1, r_m6_sc2;
    logic signed [ecr_pkg::NVW-1:0]   r_m6_v1x, r_m6_v1y, r_m6_v2x, r_m6_v2y;
    logic signed [ecr_pkg::SCW-1:0]   r_m6_s1x, r_m6_s1y, r_m6_s2x, r_m6_s2y;

    assign w_mag1 = r_m5_v1y[ecr_pkg::NVW-1] ? ecr_pkg::NVW'(-r_m5_v1y) : r_m5_v1y;
    assign w_mag2 = r_m5_v2y[ecr_pkg::NVW-1] ? ecr_pkg::NVW'(-r_m5_v2y) : r_m5_v2y;
    assign w_coef = $signed({1'b0, r_coef});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m6_vld <= 1'b0;
        end else if (en) begin
            r_m6_vld <= r_m5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m6_v1x   <= r_m5_v1x;
            r_m6_v1y   <= r_m5_v1y;
            r_m6_v2x   <= r_m5_v2x;
            r_m6_v2y   <= r_m5_v2y;
            r_m6_s1x   <= r_m5_v1x * w_coef;
            r_m6_s1y   <= r_m5_v1y * w_coef;
            r_m6_s2x   <= r_m5_v2x * w_coef;
            r_m6_s2y   <= r_m5_v2y * w_coef;
            r_m6_degen <= r_m5_degen;
            r_m6_sc1   <= !r_m5_degen && (w_mag1 > ecr_pkg::NVW'(r_minspd));
            r_m6_sc2   <= !r_m5_degen && (w_mag2 > ecr_pkg::NVW'(r_minspd));
        end
    end

    // ---- output register: pick scaled or not, saturate ----
    logic signed [63:0] w_f1x, w_f1y, w_f2x, w_f2y;

    assign w_f1x = r_m6_sc1 ? ecr_pkg::trunc_shr(64'(r_m6_s1x), ecr_pkg::COEF_FRAC)
                            : 64'(r_m6_v1x);
    assign w_f1y = r_m6_sc1 ? ecr_pkg::trunc_shr(64'(r_m6_s1y), ecr_pkg::COEF_FRAC)
                            : 64'(r_m6_v1y);
    assign w_f2x = r_m6_sc2 ? ecr_pkg::trunc_shr(64'(r_m6_s2x), ecr_pkg::COEF_FRAC)
                            : 64'(r_m6_v2x);
    assign w_f2y = r_m6_sc2 ? ecr_pkg::trunc_shr(64'(r_m6_s2y), ecr_pkg::COEF_FRAC)
                            : 64'(r_m6_v2y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_m6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_new_first_vx  <= ecr_pkg::sat_v(w_f1x);
            o_new_first_vy  <= ecr_pkg::sat_v(w_f1y);
            o_new_second_vx <= ecr_pkg::sat_v(w_f2x);
            o_new_second_vy <= ecr_pkg::sat_v(w_f2y);
            o_degenerate    <= r_m6_degen;
        end
    end

endmodule

// File: hdl/ecr_checker.sv
// ----------------------------------------------------------------------------
// ecr_checker: port-level checks for the collision pipeline
// Reset, output hold and stall consistency, attached by bind.
// ----------------------------------------------------------------------------
module ecr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [ecr_pkg::VW-1:0] o_new_first_vx,
    input logic signed [ecr_pkg::VW-1:0] o_new_first_vy,
    input logic signed [ecr_pkg::VW-1:0] o_new_second_vx,
    input logic signed [ecr_pkg::VW-1:0] o_new_second_vy,
    input logic                          o_degenerate
);

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input side stalls only when a held output beat blocks the pipeline
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output beat");

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_new_first_vx)
            && $stable(o_new_first_vy) && $stable(o_new_second_vx)
            && $stable(o_new_second_vy) && $stable(o_degenerate)))
        else $error("held output beat changed");

endmodule

bind elastic_collision_response ecr_checker u_ecr_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for elastic_collision_response
// Random and directed body pairs are streamed through the block with random
// gaps and output stalls; every output beat is compared against a local
// fixed-point model of the bounce, in order, field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int LATENCY   = 61;
    localparam int MAX_CYCLE = 2000000;

    typedef struct {
        logic signed [31:0] fx, fy, fvx, fvy, sx, sy, svx, svy;
    } t_pair;

    typedef struct {
        logic signed [31:0] v1x, v1y, v2x, v2y;
        logic               degen;
    } t_bounce;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_degenerate;
    logic signed [31:0] i_first_x = '0, i_first_y = '0, i_first_vx = '0, i_first_vy = '0;
    logic signed [31:0] i_second_x = '0, i_second_y = '0, i_second_vx = '0, i_second_vy = '0;
    logic signed [31:0] o_new_first_vx, o_new_first_vy, o_new_second_vx, o_new_second_vy;
    logic                          i_cfg_we = 1'b0;
    logic [ecr_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ecr_pkg::CFG_DW-1:0]    i_cfg_wdata = '0;

    // model copy of the two registers
    logic [16:0] coef_q = 17'd65536;
    logic [30:0] minspd_q = '0;

    t_pair   pending_pairs[$];
    t_bounce expected_bounces[$];
    int      errors = 0;
    int      cycle = 0;
    bit      hold_long = 1'b0;   // long receiver hold-off request
    bit      hold_done = 1'b0;   // long hold-off already served

    elastic_collision_response DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // toward-zero right shift
    function automatic longint shr0(longint v, int s);
        longint m;
        m = mag64(v) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // scale both components when |vy| strictly exceeds the threshold
    function automatic void apply_scale(inout longint vx, inout longint vy);
        if (mag64(vy) > longint'(minspd_q)) begin
            vx = shr0(vx * longint'(coef_q), ecr_pkg::COEF_FRAC);
            vy = shr0(vy * longint'(coef_q), ecr_pkg::COEF_FRAC);
        end
    endfunction

    function automatic t_bounce resolve_bounce(t_pair p);
        t_bounce r;
        longint dx, dy, ax, ay, mx, d, nx, ny, dot, imp, ix, iy;
        longint v1x, v1y, v2x, v2y;
        int s;
        v1x = p.fvx; v1y = p.fvy; v2x = p.svx; v2y = p.svy;
        dx = longint'(p.sx) - longint'(p.fx);
        dy = longint'(p.sy) - longint'(p.fy);
        r.degen = (dx == 0 && dy == 0);
        if (!r.degen) begin
            ax = mag64(dx);
            ay = mag64(dy);
            mx = ax > ay ? ax : ay;
            s = 0;
            while ((mx >>> s) >= 64'h8000_0000) s++;
            ax = ax >>> s;
            ay = ay >>> s;
            d = root64(ax * ax + ay * ay);
            if (d == 0) d = 1;
            nx = (ax <<< ecr_pkg::FRAC_BITS) / d;
            ny = (ay <<< ecr_pkg::FRAC_BITS) / d;
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
            dot = nx * (v1x - v2x) + ny * (v1y - v2y);
            imp = shr0(2 * dot, ecr_pkg::FRAC_BITS);
            ix = shr0(imp * nx, ecr_pkg::FRAC_BITS);
            iy = shr0(imp * ny, ecr_pkg::FRAC_BITS);
            v1x -= ix; v1y -= iy; v2x += ix; v2y += iy;
            apply_scale(v1x, v1y);
            apply_scale(v2x, v2y);
        end
        r.v1x = clamp32(v1x); r.v1y = clamp32(v1y);
        r.v2x = clamp32(v2x); r.v2y = clamp32(v2y);
        return r;
    endfunction

    // mostly short gaps, a few long ones, often none
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // stall sampled at the rising edge, for the driver's acceptance test
    logic o_stall_q = 1'b0;

    // ---------------- driver: one beat per accepted edge ----------------
    int  send_gap = 0;
    bit  sent;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // beat on the bus was taken at the last rising edge?
            sent = i_valid && !o_stall_q;
            if (sent) void'(pending_pairs.pop_front());
            if (i_valid && !sent) begin
                // stalled: hold payload
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_pairs.size() > 0 && (!sent || gap_len() == 0)) begin
                i_valid     <= 1'b1;
                i_first_x   <= pending_pairs[0].fx;
                i_first_y   <= pending_pairs[0].fy;
                i_first_vx  <= pending_pairs[0].fvx;
                i_first_vy  <= pending_pairs[0].fvy;
                i_second_x  <= pending_pairs[0].sx;
                i_second_y  <= pending_pairs[0].sy;
                i_second_vx <= pending_pairs[0].svx;
                i_second_vy <= pending_pairs[0].svy;
            end else begin
                i_valid  <= 1'b0;
                if (pending_pairs.size() > 0) send_gap <= gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        o_stall_q <= o_stall;
        // expectation is formed when the beat is accepted
        if (i_rst_n && i_valid && !o_stall) begin
            expected_bounces.push_back(resolve_bounce('{i_first_x, i_first_y, i_first_vx,
                i_first_vy, i_second_x, i_second_y, i_second_vx, i_second_vy}));
        end
    end

    // ---------------- receiver stall ----------------
    int hold_cnt = 0;
    always @(negedge i_clk) begin
        if (hold_long && !hold_done && hold_cnt == 0) begin
            hold_cnt  <= 300;
            hold_done <= 1'b1;
            i_stall   <= 1'b1;
        end else if (hold_cnt > 1) begin
            hold_cnt <= hold_cnt - 1;
        end else begin
            hold_cnt <= 0;
            i_stall <= ($urandom_range(0, 99) < 25) ? ($urandom_range(0, 9) == 0 ?
                1'b1 : 1'b1) : 1'b0;
        end
    end

    // ---------------- monitor ----------------
    t_bounce want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bounces.size() == 0) begin
                $error("output beat with nothing expected");
                errors = errors + 1;
            end else begin
                want = expected_bounces.pop_front();
                if (o_new_first_vx !== want.v1x) begin
                    $error("new_first_vx exp %0d got %0d", want.v1x, o_new_first_vx);
                    errors = errors + 1;
                end
                if (o_new_first_vy !== want.v1y) begin
                    $error("new_first_vy exp %0d got %0d", want.v1y, o_new_first_vy);
                    errors = errors + 1;
                end
                if (o_new_second_vx !== want.v2x) begin
                    $error("new_second_vx exp %0d got %0d", want.v2x, o_new_second_vx);
                    errors = errors + 1;
                end
                if (o_new_second_vy !== want.v2y) begin
                    $error("new_second_vy exp %0d got %0d", want.v2y, o_new_second_vy);
                    errors = errors + 1;
                end
                if (o_degenerate !== want.degen) begin
                    $error("degenerate exp %0d got %0d", want.degen, o_degenerate);
                    errors = errors + 1;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic signed [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000 + $urandom_range(0, 3);
            1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            2: return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        p = '{rand_field(), rand_field(), rand_field(), rand_field(),
              rand_field(), rand_field(), rand_field(), rand_field()};
        // some coincident or near-coincident pairs
        if ($urandom_range(0, 15) == 0) begin
            p.sx = p.fx; p.sy = p.fy;
        end else if ($urandom_range(0, 9) == 0) begin
            p.sx = p.fx + $signed($urandom_range(0, 4)) - 2;
            p.sy = p.fy + $signed($urandom_range(0, 4)) - 2;
        end
        return p;
    endfunction

    task automatic cfg_write(ecr_pkg::t_cfg_idx idx, logic [ecr_pkg::CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ecr_pkg::CFG_SPEED_COEF) coef_q = val[16:0];
        else if (idx == ecr_pkg::CFG_MIN_SPEED) minspd_q = val[30:0];
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || i_valid || expected_bounces.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: coincident, axis hits, extremes, opposing heads-on
        pending_pairs.push_back('{0, 0, ONE, -ONE, 0, 0, 5, 7});
        pending_pairs.push_back('{MINV, MINV, MAXV, MINV, MINV, MINV, MINV, MAXV});
        pending_pairs.push_back('{0, 0, ONE, 0, ONE, 0, -ONE, 0});
        pending_pairs.push_back('{0, 0, 0, ONE, 0, ONE, 0, -ONE});
        pending_pairs.push_back('{MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MINV});
        pending_pairs.push_back('{MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV});
        pending_pairs.push_back('{MINV, 0, MAXV, MINV, MAXV, 0, MINV, MAXV});
        pending_pairs.push_back('{0, MAXV, MAXV, MAXV, 0, MINV, MINV, MINV});
        pending_pairs.push_back('{0, 0, ONE, ONE, 1, 0, 0, 0});
        pending_pairs.push_back('{0, 0, -1, -1, 0, -1, 1, 1});
        pending_pairs.push_back('{-1, -1, 32'h1234_5678, -32'sh0765_4321, 1, 1, 3, -3});
        pending_pairs.push_back('{MAXV, 0, 0, 0, MAXV, 0, 0, 0});
        drain();

        // configuration sweep; includes masking and a dropped index
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    cfg_write(ecr_pkg::CFG_SPEED_COEF, 31'h1FFFF);
                    cfg_write(ecr_pkg::CFG_MIN_SPEED, '0);
                end
                1: begin
                    cfg_write(ecr_pkg::CFG_SPEED_COEF, '0);
                    cfg_write(ecr_pkg::CFG_MIN_SPEED, 31'h7FFF_FFFF);
                end
                2: begin
                    cfg_write(ecr_pkg::CFG_SPEED_COEF, 31'h7FFE_8000);
                    cfg_write(ecr_pkg::CFG_MIN_SPEED, 31'(ONE));
                end
                3: begin
                    cfg_write(ecr_pkg::CFG_SPEED_COEF, 31'($urandom_range(0, 131071)));
                    cfg_write(ecr_pkg::CFG_MIN_SPEED, 31'($urandom_range(0, 32'h0100_0000)));
                    // index beyond the list must be dropped
                    @(negedge i_clk);
                    i_cfg_we <= 1'b1; i_cfg_idx <= 2'd3; i_cfg_wdata <= '1;
                    @(negedge i_clk);
                    i_cfg_we <= 1'b0;
                end
                4: begin
                    cfg_write(ecr_pkg::CFG_SPEED_COEF, '0);
                    cfg_write(ecr_pkg::CFG_MIN_SPEED, '0);
                end
                default: begin
                    cfg_write(ecr_pkg::CFG_SPEED_COEF, 31'd65536);
                    cfg_write(ecr_pkg::CFG_MIN_SPEED, '0);
                end
            endcase
            for (int n = 0; n < 130; n++) pending_pairs.push_back(rand_pair());
            if (phase == 2) hold_long = 1'b1;
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: elastic_collision_response.f
hdl/ecr_pkg.sv
hdl/elastic_collision_response.sv
hdl/ecr_checker.sv
sim/tb.sv
